### rtl/sound_sample_dma_channel_core_macros.svh
// Assertion macros used by the sample DMA channel step module (sdma_step).
`ifndef SOUND_SAMPLE_DMA_CHANNEL_CORE_MACROS_SVH
`define SOUND_SAMPLE_DMA_CHANNEL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SDMA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SDMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SDMA_ASSERT(label, ante, cons, msg)
`define SDMA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/sdma_pkg.sv
// Types, constants and helper functions for the sample DMA channel.
`timescale 1ns / 1ps

package sdma_pkg;

  localparam int ADDRESS_BITS_DEF = 20;
  localparam int LEN_BITS         = 20;
  localparam int FETCH_ADDR_BITS  = 20;
  localparam int WIDE_BITS        = 24;   // three byte lanes

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  // register offsets
  localparam logic [2:0] OFF_SRC_LO = 3'd0;
  localparam logic [2:0] OFF_SRC_MD = 3'd1;
  localparam logic [2:0] OFF_SRC_HI = 3'd2;
  localparam logic [2:0] OFF_LEN_LO = 3'd4;
  localparam logic [2:0] OFF_LEN_MD = 3'd5;
  localparam logic [2:0] OFF_LEN_HI = 3'd6;

  // byte lanes
  localparam logic [1:0] LANE_LO = 2'd0;
  localparam logic [1:0] LANE_MD = 2'd1;
  localparam logic [1:0] LANE_HI = 2'd2;

  // control register bits
  localparam int CTL_ENABLE_BIT = 7;
  localparam int CTL_DOWN_BIT   = 6;
  localparam int CTL_HYPER_BIT  = 4;
  localparam int CTL_REPEAT_BIT = 3;
  localparam logic [7:0] CTL_WR_MASK = ~8'h20;

  // rate select codes and timer reload values
  localparam logic [1:0] RATE_0 = 2'd0;
  localparam logic [1:0] RATE_1 = 2'd1;
  localparam logic [1:0] RATE_2 = 2'd2;
  localparam logic [2:0] TMR_RATE_0 = 3'd5;
  localparam logic [2:0] TMR_RATE_1 = 3'd3;
  localparam logic [2:0] TMR_RATE_2 = 3'd1;
  localparam logic [2:0] TMR_RATE_3 = 3'd0;

  typedef struct packed {
    opcode_t    opcode;
    logic [2:0] reg_offset;
    logic       reg_is_control;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]                 read_data;
    logic                       fetch_valid;
    logic [FETCH_ADDR_BITS-1:0] fetch_address;
    logic                       fetch_target;
    logic                       channel_active;
  } result_t;

  function automatic logic [2:0] rate_reload(input logic [1:0] rate);
    logic [2:0] t;
    case (rate)
      RATE_0:  t = TMR_RATE_0;
      RATE_1:  t = TMR_RATE_1;
      RATE_2:  t = TMR_RATE_2;
      default: t = TMR_RATE_3;
    endcase
    return t;
  endfunction

  function automatic logic [WIDE_BITS-1:0] put_lane(input logic [WIDE_BITS-1:0] w,
                                                    input logic [1:0] lane,
                                                    input logic [7:0] b);
    logic [WIDE_BITS-1:0] r;
    r = w;
    case (lane)
      LANE_LO: r[7:0]   = b;
      LANE_MD: r[15:8]  = b;
      LANE_HI: r[23:16] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] get_lane(input logic [WIDE_BITS-1:0] w,
                                          input logic [1:0] lane);
    logic [7:0] r;
    case (lane)
      LANE_LO: r = w[7:0];
      LANE_MD: r = w[15:8];
      LANE_HI: r = w[23:16];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/sdma_in_reg.sv
// Input register stage: holds one accepted beat until the step stage takes it.
`timescale 1ns / 1ps

module sdma_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  sdma_pkg::item_t in_item,
  output logic            in_stall,
  input  logic            down_ready,
  output logic            item_valid,
  output sdma_pkg::item_t item
);

  logic            vld_r, vld_nxt;
  sdma_pkg::item_t item_r;
  logic            load;

  assign in_stall = vld_r && !down_ready;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (down_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

### rtl/sdma_step.sv
// Channel state registers and the combinational tick / register access logic.
`timescale 1ns / 1ps
`include "sound_sample_dma_channel_core_macros.svh"

module sdma_step #(
  parameter int ADDRESS_BITS = sdma_pkg::ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sdma_pkg::item_t   item,
  output sdma_pkg::result_t res
);

  localparam int LB = sdma_pkg::LEN_BITS;
  localparam int WB = sdma_pkg::WIDE_BITS;

  logic [ADDRESS_BITS-1:0] src_r, src_nxt, srl_r, srl_nxt;
  logic [LB-1:0]           len_r, len_nxt, lrl_r, lrl_nxt, len_dec;
  logic [7:0]              ctl_r, ctl_nxt;
  logic [2:0]              tmr_r, tmr_nxt;
  logic [WB-1:0]           src_wide, len_wide, src_put, len_put;
  logic [1:0]              lane;

  assign src_wide = WB'(src_r);
  assign len_wide = WB'(len_r);
  assign len_dec  = len_r - 1'b1;
  // source and length lanes share the low offset bits
  assign lane     = item.reg_offset[1:0];
  assign src_put  = sdma_pkg::put_lane(src_wide, lane, item.write_data);
  assign len_put  = sdma_pkg::put_lane(len_wide, lane, item.write_data);

  always_comb begin
    src_nxt = src_r;
    srl_nxt = srl_r;
    len_nxt = len_r;
    lrl_nxt = lrl_r;
    ctl_nxt = ctl_r;
    tmr_nxt = tmr_r;
    res     = '0;
    case (item.opcode)
      sdma_pkg::OP_TICK: begin
        if (ctl_r[sdma_pkg::CTL_ENABLE_BIT]) begin
          if (tmr_r == 3'd0) begin
            res.fetch_valid   = 1'b1;
            res.fetch_address = src_wide[sdma_pkg::FETCH_ADDR_BITS-1:0];
            res.fetch_target  = ctl_r[sdma_pkg::CTL_HYPER_BIT];
            src_nxt = ctl_r[sdma_pkg::CTL_DOWN_BIT] ? src_r - 1'b1 : src_r + 1'b1;
            len_nxt = len_dec;
            // end of block: loop back or stop
            if (len_dec == '0) begin
              if (ctl_r[sdma_pkg::CTL_REPEAT_BIT]) begin
                len_nxt = lrl_r;
                src_nxt = srl_r;
              end else begin
                ctl_nxt[sdma_pkg::CTL_ENABLE_BIT] = 1'b0;
              end
            end
            tmr_nxt = sdma_pkg::rate_reload(ctl_r[1:0]);
          end else begin
            tmr_nxt = tmr_r - 1'b1;
          end
        end
      end
      sdma_pkg::OP_WRITE: begin
        if (item.reg_is_control) begin
          ctl_nxt = item.write_data & sdma_pkg::CTL_WR_MASK;
        end else begin
          case (item.reg_offset)
            sdma_pkg::OFF_SRC_LO, sdma_pkg::OFF_SRC_MD, sdma_pkg::OFF_SRC_HI: begin
              src_nxt = src_put[ADDRESS_BITS-1:0];
              srl_nxt = src_put[ADDRESS_BITS-1:0];
            end
            sdma_pkg::OFF_LEN_LO, sdma_pkg::OFF_LEN_MD, sdma_pkg::OFF_LEN_HI: begin
              len_nxt = len_put[LB-1:0];
              lrl_nxt = len_put[LB-1:0];
            end
            default: ;
          endcase
        end
      end
      sdma_pkg::OP_READ: begin
        if (item.reg_is_control) begin
          res.read_data = ctl_r;
        end else begin
          case (item.reg_offset)
            sdma_pkg::OFF_SRC_LO, sdma_pkg::OFF_SRC_MD, sdma_pkg::OFF_SRC_HI:
              res.read_data = sdma_pkg::get_lane(src_wide, lane);
            sdma_pkg::OFF_LEN_LO, sdma_pkg::OFF_LEN_MD, sdma_pkg::OFF_LEN_HI:
              res.read_data = sdma_pkg::get_lane(len_wide, lane);
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res.channel_active = ctl_nxt[sdma_pkg::CTL_ENABLE_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      srl_r <= '0;
      len_r <= '0;
      lrl_r <= '0;
      ctl_r <= '0;
      tmr_r <= '0;
    end else if (fire) begin
      src_r <= src_nxt;
      srl_r <= srl_nxt;
      len_r <= len_nxt;
      lrl_r <= lrl_nxt;
      ctl_r <= ctl_nxt;
      tmr_r <= tmr_nxt;
    end
  end

  `SDMA_ASSERT(a_fetch_only_on_tick, fire && res.fetch_valid, item.opcode == sdma_pkg::OP_TICK && ctl_r[sdma_pkg::CTL_ENABLE_BIT] && tmr_r == 3'd0, "fetch outside an enabled tick at timer zero")
  `SDMA_ASSERT(a_read_data_only_on_read, fire && res.read_data != 8'd0, item.opcode == sdma_pkg::OP_READ, "read data driven on a non-read beat")
  `SDMA_ASSERT_NEXT(a_timer_counts_down, fire && item.opcode == sdma_pkg::OP_TICK && ctl_r[sdma_pkg::CTL_ENABLE_BIT] && tmr_r != 3'd0, tmr_r == $past(tmr_r) - 3'd1, "rate timer did not count down")
  `SDMA_ASSERT_NEXT(a_timer_reload, fire && res.fetch_valid, tmr_r == sdma_pkg::rate_reload($past(ctl_r[1:0])), "rate timer not reloaded after fetch")
  `SDMA_ASSERT_NEXT(a_state_holds_when_idle, !fire, $stable(ctl_r) && $stable(src_r) && $stable(len_r), "channel state changed without a beat")

endmodule

### rtl/sdma_out_reg.sv
// Result register stage: holds a finished result until the consumer takes it.
`timescale 1ns / 1ps

module sdma_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  sdma_pkg::result_t res,
  output logic              ready,
  output logic              take,
  input  logic              out_stall,
  output logic              out_valid,
  output sdma_pkg::result_t out_res
);

  logic              vld_r, vld_nxt;
  sdma_pkg::result_t res_r;

  assign ready = !vld_r || !out_stall;
  assign take  = res_valid && ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

### rtl/sound_sample_dma_channel_core.sv
// Top level of the sound-sample DMA channel core.
`timescale 1ns / 1ps

// One beat per clock in sustained flow while out_stall is low: every beat (tick,
// register write or register read) gives one result beat, registered first in the
// input register and then, through the channel state update, in the result register.
// The state update (source step, length decrement, timer reload) is combinational
// between the two registers, which is what sets the one-beat-per-cycle rate. in_stall rises
// only when both the input register and the result register hold beats and out_stall is high.
module sound_sample_dma_channel_core #(
  parameter int ADDRESS_BITS = sdma_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_reg_offset,
  input  logic        in_reg_is_control,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_fetch_valid,
  output logic [19:0] out_fetch_address,
  output logic        out_fetch_target,
  output logic        out_channel_active
);

  sdma_pkg::item_t   in_item, item;
  sdma_pkg::result_t res, out_res;
  logic              item_valid, ready, take;

  always_comb begin
    in_item.opcode         = sdma_pkg::opcode_t'(in_opcode);
    in_item.reg_offset     = in_reg_offset;
    in_item.reg_is_control = in_reg_is_control;
    in_item.write_data     = in_write_data;
  end

  sdma_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .down_ready (ready),
    .item_valid (item_valid),
    .item       (item)
  );

  sdma_step #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (item),
    .res   (res)
  );

  sdma_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .ready     (ready),
    .take      (take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_read_data      = out_res.read_data;
  assign out_fetch_valid    = out_res.fetch_valid;
  assign out_fetch_address  = out_res.fetch_address;
  assign out_fetch_target   = out_res.fetch_target;
  assign out_channel_active = out_res.channel_active;

endmodule
